// File: design/dlpd_pkg.sv
// Shared types and constants for the decimal list parser with duplicate check.
`timescale 1ns / 1ps
`default_nettype none

package dlpd_pkg;

  // Input selector codes (in_tuser)
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes (out_tuser)
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_SKIPPED  = 3'd5;

  // Argument fault codes
  localparam logic [1:0] FLT_NONE     = 2'd0;
  localparam logic [1:0] FLT_BAD      = 2'd1;
  localparam logic [1:0] FLT_OVERFLOW = 2'd2;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Magnitude limits, widened to hold ten times a 32-bit magnitude plus a digit
  localparam int unsigned ACC_W = 36;
  localparam logic [ACC_W-1:0] LIMIT_POS = 36'h0_7FFF_FFFF;
  localparam logic [ACC_W-1:0] LIMIT_NEG = 36'h0_8000_0000;

  // Argument state seen by the control logic
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic        digit_seen;
    logic [1:0]  fault;
  } tok_t;

endpackage

`default_nettype wire

// File: design/dlpd_parser.sv
// Character accumulator: sign, digit magnitude and fault tracking for one argument.
`timescale 1ns / 1ps
`default_nettype none

module dlpd_parser
  import dlpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_en,
  input  wire logic       clr,
  input  wire logic [7:0] ch,
  input  wire logic       list_failed,
  output tok_t            tok
);

  logic [31:0] mag_r;
  logic        neg_r;
  logic        digit_r;
  logic [1:0]  fault_r;
  logic        first_r;

  logic             is_sign;
  logic             is_digit;
  logic [3:0]       digit;
  logic [ACC_W-1:0] mag_ext;
  logic [ACC_W-1:0] next_mag;
  logic [ACC_W-1:0] limit;

  // times ten as two shifts, plus the new digit
  always_comb begin
    is_sign  = (ch == CH_MINUS) || (ch == CH_PLUS);
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit    = 4'(ch - CH_ZERO);
    mag_ext  = {{(ACC_W-32){1'b0}}, mag_r};
    next_mag = (mag_ext << 3) + (mag_ext << 1) + {{(ACC_W-4){1'b0}}, digit};
    limit    = neg_r ? LIMIT_NEG : LIMIT_POS;
  end

  // argument state; first fault sticks until the argument ends
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      mag_r   <= '0;
      neg_r   <= 1'b0;
      digit_r <= 1'b0;
      fault_r <= FLT_NONE;
      first_r <= 1'b1;
    end else if (byte_en) begin
      first_r <= 1'b0;
      if (!list_failed && fault_r == FLT_NONE) begin
        if (first_r && is_sign) begin
          neg_r <= (ch == CH_MINUS);
        end else if (!is_digit) begin
          fault_r <= FLT_BAD;
        end else begin
          digit_r <= 1'b1;
          if (next_mag > limit) begin
            fault_r <= FLT_OVERFLOW;
          end else begin
            mag_r <= next_mag[31:0];
          end
        end
      end
    end
  end

  assign tok.mag        = mag_r;
  assign tok.neg        = neg_r;
  assign tok.digit_seen = digit_r;
  assign tok.fault      = fault_r;

endmodule

`default_nettype wire

// File: design/dlpd_store.sv
// Value store: single-port-write, registered-read memory for the stored list.
`timescale 1ns / 1ps
`default_nettype none

module dlpd_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [31:0]      wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [31:0]      rd_data
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/decimal_list_parse_dedup_unit.sv
// Top level: decimal argument parser with duplicate scan over the value store.
// Character and clear transfers give no result.
// An argument end goes straight to the emit state when no scan is needed, otherwise
// through the scan state, which a duplicate ends early; emit then waits for a free
// output slot. The scan reads one stored value per cycle via the single memory read port.
// One item is in work at a time.
// Reset clears all control state; store contents stay undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module decimal_list_parse_dedup_unit
  import dlpd_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] parsed_value, [38:32] stored_count,
                                       // [39] list_ok, [40] list_sorted, rest zero
  output logic [2:0]       out_tuser   // [2:0] status
);

  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STORE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic             cmp_vld_r;
  logic             dup_r;
  logic             failed_r;
  logic             sorted_r;
  logic [31:0]      last_r;
  logic [31:0]      val_r;
  logic [2:0]       pre_st_r;

  logic        out_valid_r;
  logic [2:0]  out_st_r;
  logic [31:0] out_val_r;
  logic [6:0]  out_cnt_r;
  logic        out_ok_r;
  logic        out_sorted_r;

  tok_t        tok;
  logic        acc;
  logic        acc_char, acc_end, acc_clr;
  logic [2:0]  pre_st;
  logic [31:0] tok_val;
  logic        hit;
  logic        scan_issue;
  logic        slot_free;
  logic        emit;
  logic [2:0]  fin_st;
  logic        do_store;
  logic [31:0] rd_data;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W+6:0] cnt_ext;

  // input side
  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign acc_char  = acc && (in_tuser == OP_CHAR);
  assign acc_end   = acc && (in_tuser == OP_END);
  assign acc_clr   = acc && (in_tuser == OP_CLEAR);

  dlpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (acc_char),
    .clr         (acc_end || acc_clr),
    .ch          (in_tdata),
    .list_failed (failed_r),
    .tok         (tok)
  );

  // status known at argument end, before the scan
  always_comb begin
    tok_val = tok.neg ? (32'd0 - tok.mag) : tok.mag;
    priority if (failed_r) begin
      pre_st = ST_SKIPPED;
    end else if (tok.fault == FLT_OVERFLOW) begin
      pre_st = ST_OVERFLOW;
    end else if (tok.fault != FLT_NONE || !tok.digit_seen) begin
      pre_st = ST_BAD;
    end else begin
      pre_st = ST_STORED;
    end
  end

  // duplicate scan over entries below the fill count
  assign hit        = cmp_vld_r && (rd_data == val_r);
  assign scan_issue = (state_r == S_SCAN) && !hit && (scan_idx_r != count_r);

  dlpd_store #(
    .DEPTH (STORE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_store),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (val_r),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // final status and commit
  assign slot_free = !out_valid_r || out_tready;
  assign emit      = (state_r == S_EMIT) && slot_free;

  always_comb begin
    priority if (pre_st_r != ST_STORED) begin
      fin_st = pre_st_r;
    end else if (dup_r) begin
      fin_st = ST_DUP;
    end else if (count_r == CNT_FULL) begin
      fin_st = ST_FULL;
    end else begin
      fin_st = ST_STORED;
    end
  end

  assign do_store  = emit && (fin_st == ST_STORED);
  assign count_inc = count_r + CNT_W'(1);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_end) begin
          state_nxt = (pre_st == ST_STORED && count_r != '0) ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (hit || scan_idx_r == count_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      dup_r      <= 1'b0;
      failed_r   <= 1'b0;
      sorted_r   <= 1'b1;
      last_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= scan_issue;
      if (scan_issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      if (state_r == S_SCAN && hit) begin
        dup_r <= 1'b1;
      end
      if (acc_clr) begin
        count_r  <= '0;
        failed_r <= 1'b0;
        sorted_r <= 1'b1;
        last_r   <= '0;
      end
      if (acc_end) begin
        scan_idx_r <= '0;
        dup_r      <= 1'b0;
      end
      if (emit) begin
        if (fin_st != ST_STORED) begin
          failed_r <= 1'b1;
        end else begin
          count_r <= count_inc;
          last_r  <= val_r;
          if (count_r != '0 && $signed(val_r) <= $signed(last_r)) begin
            sorted_r <= 1'b0;
          end
        end
      end
    end
  end

  // argument held for the scan
  always_ff @(posedge clk) begin
    if (acc_end) begin
      val_r    <= tok_val;
      pre_st_r <= pre_st;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign cnt_ext = {7'd0, (do_store ? count_inc : count_r)};

  always_ff @(posedge clk) begin
    if (emit) begin
      out_st_r     <= fin_st;
      out_val_r    <= do_store ? val_r : 32'd0;
      out_cnt_r    <= cnt_ext[6:0];
      out_ok_r     <= !failed_r && do_store;
      out_sorted_r <= do_store ? (sorted_r && !(count_r != '0 &&
                      $signed(val_r) <= $signed(last_r))) : sorted_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {7'd0, out_sorted_r, out_ok_r, out_cnt_r, out_val_r};

`ifndef NO_ASSERTIONS
  a_wr_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    do_store |-> (count_r < CNT_FULL))
    else $error("store write at full count");

  a_rd_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    scan_issue |-> (scan_idx_r < count_r))
    else $error("scan read beyond fill count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_store |=> (count_r == $past(count_inc)))
    else $error("fill count did not advance after store");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_STORED) |-> (out_tdata[31:0] == 32'd0))
    else $error("value not zero on failed argument");
`endif

endmodule

`default_nettype wire
